// File: rtl/core/tdlm_pkg.sv
`default_nettype none

package tdlm_pkg;

  // Default sizes of the automaton and the stored string
  localparam int NumStates  = 16;
  localparam int NumClasses = 8;
  localparam int MaxString  = 32;

  // Field widths of the item, result and register ports
  localparam int OpW     = 3;
  localparam int CharW   = 8;
  localparam int StIdxW  = 4;
  localparam int ClIdxW  = 3;
  localparam int PosW    = 5;
  localparam int CountW  = 16;
  localparam int LenW    = 6;
  localparam int CfgIdxW = 1;

  localparam logic [CountW-1:0] CountMax = '1;

  // Item operations
  typedef enum logic [OpW-1:0] {
    OP_RESTART  = 3'd0,
    OP_FEED     = 3'd1,
    OP_WR_TRANS = 3'd2,
    OP_WR_END   = 3'd3,
    OP_WR_CLASS = 3'd4,
    OP_WR_CHAR  = 3'd5
  } op_e;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONST_MODE    = 1'b0,
    CFG_STRING_LENGTH = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/core/table_dfa_longest_match.sv
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    opcode, char_in, state_index, class_index,
//                                                next_state, flag_bit, string_pos
// out      output     out_valid_o / out_ready_i  accepted, alive, cur_state, char_count,
//                                                fit_len, full_match
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index, cfg_data
//
// Each item goes through the class memory read, then the state-fed transition read, and its result
// is then loaded into the output register; a new item is taken only after the last has left the class read.
// After reset the class and transition memories are cleared, one entry a cycle, over
// max(256, NUM_STATES*NUM_CLASSES) entries (256 by default); no item is taken meanwhile.
// A waiting result does not block acceptance; only a second result behind it stalls input.
// A register write is taken only while no item is in flight.
module table_dfa_longest_match #(
  parameter int NUM_STATES  = tdlm_pkg::NumStates,
  parameter int NUM_CLASSES = tdlm_pkg::NumClasses,
  parameter int MAX_STRING  = tdlm_pkg::MaxString
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // item channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tdlm_pkg::OpW-1:0]      opcode_i,
  input  wire logic [tdlm_pkg::CharW-1:0]    char_in_i,
  input  wire logic [tdlm_pkg::StIdxW-1:0]   state_index_i,
  input  wire logic [tdlm_pkg::ClIdxW-1:0]   class_index_i,
  input  wire logic [tdlm_pkg::StIdxW-1:0]   next_state_i,
  input  wire logic                          flag_bit_i,
  input  wire logic [tdlm_pkg::PosW-1:0]     string_pos_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               accepted_o,
  output logic                               alive_o,
  output logic      [tdlm_pkg::StIdxW-1:0]   cur_state_o,
  output logic      [tdlm_pkg::CountW-1:0]   char_count_o,
  output logic      [tdlm_pkg::CountW-1:0]   fit_len_o,
  output logic                               full_match_o,
  // configuration channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tdlm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tdlm_pkg::LenW-1:0]     cfg_data_i
);

  localparam int SW       = $clog2(NUM_STATES);
  localparam int CW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW       = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;
  localparam int TDepth   = NUM_STATES * NUM_CLASSES;
  localparam int TAW      = $clog2(TDepth);
  localparam int ClsDepth = 1 << tdlm_pkg::CharW;
  localparam int ClrDepth = (TDepth > ClsDepth) ? TDepth : ClsDepth;
  localparam int ClrW     = $clog2(ClrDepth);
  localparam int CntW     = tdlm_pkg::CountW;

  // handshake and pipeline control
  logic            in_acc;
  logic            s1_q, s1_d;
  logic            s2_q, s2_d;
  logic            s2_go;
  logic            clr_busy_q, clr_busy_d;
  logic [ClrW-1:0] clr_cnt_q, clr_cnt_d;

  // item held from acceptance through the first and second work cycles
  tdlm_pkg::op_e                 op_q;
  logic [tdlm_pkg::CharW-1:0]    char_q;
  logic [tdlm_pkg::StIdxW-1:0]   st_q;
  logic [tdlm_pkg::ClIdxW-1:0]   cl_q;
  logic [tdlm_pkg::StIdxW-1:0]   nx_q;
  logic                          fb_q;
  logic [tdlm_pkg::PosW-1:0]     pos_q;

  // configuration registers
  logic                          mode_q;
  logic [tdlm_pkg::LenW-1:0]     len_q;

  // scan state
  logic [SW-1:0]   state_q, state_d;
  logic            alive_q, alive_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [CntW-1:0] fit_q, fit_d;
  logic            match_q, match_d;
  logic            acc;
  logic [NUM_STATES-1:0] endf_q;

  // memory ports
  logic                       cls_we;
  logic [tdlm_pkg::CharW-1:0] cls_waddr;
  logic [NUM_CLASSES-1:0]     cls_wdata, cls_mod, cls_rdata;
  logic                       cls_any;
  logic [CW-1:0]              cls_sel;
  logic                       tr_we;
  logic [TAW-1:0]             tr_waddr, tr_raddr;
  logic [SW:0]                tr_wdata, tr_rdata;
  logic                       pat_we;
  logic [tdlm_pkg::CharW-1:0] pat_rdata;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic                          out_acc_q;
  logic                          out_alive_q;
  logic [tdlm_pkg::StIdxW-1:0]   out_state_q;
  logic [CntW-1:0]               out_cnt_q;
  logic [CntW-1:0]               out_fit_q;
  logic                          out_match_q;

  // ------------------------------------------------------------------
  // Handshake: one item in flight, result stage may park in the output register
  assign s2_go      = s2_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && !s1_q && !(s2_q && !s2_go);
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_d       = in_acc;
  assign s2_d       = s1_q ? 1'b1 : (s2_go ? 1'b0 : s2_q);
  assign out_valid_d = s2_go ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Advance the memory clearing sweep after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ClrW'(ClrDepth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  // Capture the item at acceptance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= tdlm_pkg::op_e'(opcode_i);
      char_q <= char_in_i;
      st_q   <= state_index_i;
      cl_q   <= class_index_i;
      nx_q   <= next_state_i;
      fb_q   <= flag_bit_i;
      pos_q  <= string_pos_i;
    end
  end

  // ------------------------------------------------------------------
  // Configuration registers, ready only while no item is in flight
  assign cfg_ready_o = !s1_q && !s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      len_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tdlm_pkg::cfg_idx_e'(cfg_index_i))
        tdlm_pkg::CFG_CONST_MODE:    mode_q <= cfg_data_i[0];
        tdlm_pkg::CFG_STRING_LENGTH: len_q  <= cfg_data_i;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Class memory: read at acceptance, read-modify-write of one bit in the first cycle
  always_comb begin
    cls_mod = cls_rdata;
    cls_mod[CW'(cl_q)] = fb_q;
  end

  assign cls_we    = clr_busy_q ? (int'(clr_cnt_q) < ClsDepth)
                                : (s1_q && (op_q == tdlm_pkg::OP_WR_CLASS)
                                   && (int'(cl_q) < NUM_CLASSES));
  assign cls_waddr = clr_busy_q ? clr_cnt_q[tdlm_pkg::CharW-1:0] : char_q;
  assign cls_wdata = clr_busy_q ? '0 : cls_mod;

  tdlm_ram #(
    .Width (NUM_CLASSES),
    .Depth (ClsDepth)
  ) u_cls_ram (
    .clk_i   (clk_i),
    .we_i    (cls_we),
    .waddr_i (cls_waddr),
    .wdata_i (cls_wdata),
    .re_i    (in_acc),
    .raddr_i (char_in_i),
    .rdata_o (cls_rdata)
  );

  // Pick the lowest class the character belongs to
  always_comb begin
    cls_sel = '0;
    for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
      if (cls_rdata[j]) begin
        cls_sel = CW'(j);
      end
    end
  end

  assign cls_any = |cls_rdata;

  // ------------------------------------------------------------------
  // Transition memory: valid bit over target, read in the first cycle
  assign tr_we    = clr_busy_q ? (int'(clr_cnt_q) < TDepth)
                               : (s1_q && (op_q == tdlm_pkg::OP_WR_TRANS)
                                  && (int'(st_q) < NUM_STATES)
                                  && (int'(cl_q) < NUM_CLASSES)
                                  && (int'(nx_q) < NUM_STATES));
  assign tr_waddr = clr_busy_q ? clr_cnt_q[TAW-1:0]
                               : TAW'(TAW'(st_q) * TAW'(NUM_CLASSES) + TAW'(cl_q));
  assign tr_wdata = clr_busy_q ? '0 : {1'b1, SW'(nx_q)};
  assign tr_raddr = TAW'(TAW'(state_q) * TAW'(NUM_CLASSES) + TAW'(cls_sel));

  tdlm_ram #(
    .Width (SW + 1),
    .Depth (TDepth)
  ) u_tr_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .re_i    (s1_q),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  // ------------------------------------------------------------------
  // Pattern memory: read at the count the scan holds after the previous item
  assign pat_we = s1_q && (op_q == tdlm_pkg::OP_WR_CHAR) && (int'(pos_q) < MAX_STRING);

  tdlm_ram #(
    .Width (tdlm_pkg::CharW),
    .Depth (MAX_STRING)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (PW'(pos_q)),
    .wdata_i (char_q),
    .re_i    (in_acc),
    .raddr_i (cnt_d[PW-1:0]),
    .rdata_o (pat_rdata)
  );

  // End flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      endf_q <= '0;
    end else if (s1_q && (op_q == tdlm_pkg::OP_WR_END) && (int'(st_q) < NUM_STATES)) begin
      endf_q[SW'(st_q)] <= fb_q;
    end
  end

  // ------------------------------------------------------------------
  // Second cycle: update the scan and form the result
  assign cnt_inc = (cnt_q == tdlm_pkg::CountMax) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    state_d = state_q;
    alive_d = alive_q;
    cnt_d   = cnt_q;
    fit_d   = fit_q;
    match_d = match_q;
    acc     = 1'b0;
    if (s2_go) begin
      unique case (op_q)
        tdlm_pkg::OP_RESTART: begin
          state_d = '0;
          alive_d = 1'b1;
          cnt_d   = '0;
          fit_d   = '0;
          match_d = 1'b0;
        end
        tdlm_pkg::OP_FEED: begin
          if (char_q != '0) begin
            if (mode_q) begin
              // constant mode: compare with the stored string at the current position
              if ((cnt_q < CntW'(len_q)) && (cnt_q < CntW'(MAX_STRING))
                  && (pat_rdata == char_q)) begin
                acc   = 1'b1;
                cnt_d = cnt_inc;
                if (cnt_inc == CntW'(len_q)) begin
                  match_d = 1'b1;
                  fit_d   = CntW'(len_q);
                end
              end
            end else if (alive_q) begin
              // table mode: no class kills uncounted, missing entry kills counted
              if (!cls_any) begin
                alive_d = 1'b0;
              end else begin
                cnt_d = cnt_inc;
                if (!tr_rdata[SW]) begin
                  alive_d = 1'b0;
                end else begin
                  acc     = 1'b1;
                  state_d = tr_rdata[SW-1:0];
                  if (endf_q[tr_rdata[SW-1:0]]) begin
                    fit_d = cnt_inc;
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      alive_q <= 1'b1;
      cnt_q   <= '0;
      fit_q   <= '0;
      match_q <= 1'b0;
    end else begin
      state_q <= state_d;
      alive_q <= alive_d;
      cnt_q   <= cnt_d;
      fit_q   <= fit_d;
      match_q <= match_d;
    end
  end

  // Load the output register with the status after the item
  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      out_acc_q   <= acc;
      out_alive_q <= alive_d;
      out_state_q <= alive_d ? tdlm_pkg::StIdxW'(state_d) : '0;
      out_cnt_q   <= cnt_d;
      out_fit_q   <= fit_d;
      out_match_q <= match_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = out_acc_q;
  assign alive_o      = out_alive_q;
  assign cur_state_o  = out_state_q;
  assign char_count_o = out_cnt_q;
  assign fit_len_o    = out_fit_q;
  assign full_match_o = out_match_q;

`ifndef SYNTHESIS
  // The two work cycles of an item never overlap another item
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(s1_q && s2_q))
    else $error("first and second work cycles overlap");

  // An item in its first cycle always reaches the second
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_q |=> s2_q)
    else $error("item lost between work cycles");

  // No item is taken while the memories are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !in_ready_o)
    else $error("item accepted during memory clear");

  // A dead scan reports state zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !alive_o) |-> (cur_state_o == '0))
    else $error("dead scan reports a nonzero state");

  // The fit length never lies beyond the consumed count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (fit_len_o <= char_count_o))
    else $error("fit length exceeds character count");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tdlm_ram.sv
`default_nettype none

module tdlm_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read data; hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
